/* sv/nmx_pkg.sv */
// Shared types, constants and sine table functions for the NCO mixer with PLL.
`default_nettype none

package nmx_pkg;

  localparam int SAMPLE_BITS    = 16;
  localparam int WORD_BITS      = 32;
  localparam int GAIN_BITS      = 18;
  localparam int CMD_BITS       = 3;
  localparam int CFG_INDEX_BITS = 4;

  localparam int TABLE_ENTRIES_DEF = 1024;
  localparam int PHASE_BITS_DEF    = 32;
  localparam int QUEUE_DEPTH_DEF   = 4;

  localparam logic [GAIN_BITS-1:0] FREQ_GAIN_RESET  = 18'd6554;
  localparam logic [GAIN_BITS-1:0] PHASE_GAIN_RESET = 18'd20724;

  localparam logic [CFG_INDEX_BITS-1:0] REG_FREQ_GAIN  = 4'd0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_PHASE_GAIN = 4'd1;

  // Pi in unsigned Q2.62.
  localparam logic [63:0] PI_Q62 = 64'hC90F_DAA2_2168_C234;

  typedef enum logic [CMD_BITS-1:0] {
    CMD_MIX_UP    = 3'd0,
    CMD_MIX_DOWN  = 3'd1,
    CMD_PLL       = 3'd2,
    CMD_SET_FREQ  = 3'd3,
    CMD_ADJ_FREQ  = 3'd4,
    CMD_SET_PHASE = 3'd5,
    CMD_ADJ_PHASE = 3'd6,
    CMD_STEP      = 3'd7
  } cmd_e;

  typedef enum logic [1:0] {
    MIX_NONE,
    MIX_UP,
    MIX_DOWN
  } mix_e;

  typedef enum logic [1:0] {
    FREQ_KEEP,
    FREQ_LOAD,
    FREQ_ADD
  } freq_op_e;

  typedef enum logic [1:0] {
    PH_KEEP,
    PH_LOAD,
    PH_ADD,
    PH_STEP
  } phase_op_e;

  typedef struct packed {
    mix_e      mix;
    freq_op_e  fop;
    phase_op_e pop;
  } op_ctrl_t;

  // (a * b) >> 62, truncated to 64 bits.
  function automatic logic [63:0] mul_q62(input logic [63:0] a, input logic [63:0] b);
    logic [127:0] p;
    p = a * b;
    return p[125:62];
  endfunction

  // Restoring long division, used only while the table is built.
  function automatic logic [63:0] div_u64(input logic [63:0] a, input logic [63:0] d);
    logic [63:0] q;
    logic [63:0] r;
    q = '0;
    r = '0;
    for (int k = 63; k >= 0; k--) begin
      r = {r[62:0], a[k]};
      if (r >= d) begin
        r    = r - d;
        q[k] = 1'b1;
      end
    end
    return q;
  endfunction

  // Taylor series sine of a Q62 angle in the first quadrant.
  function automatic logic [63:0] sine_q62(input logic [63:0] x);
    logic [63:0] sum;
    logic [63:0] term;
    logic [63:0] x2;
    sum  = x;
    term = x;
    x2   = mul_q62(x, x);
    for (int n = 3; n < 64; n += 2) begin
      term = div_u64(mul_q62(term, x2), 64'((n - 1) * n));
      if (((n >> 1) & 1) == 1) begin
        sum = sum - term;
      end else begin
        sum = sum + term;
      end
    end
    return sum;
  endfunction

  // Rounded, saturated quarter-wave entry k of an n-entry table.
  function automatic logic [SAMPLE_BITS-1:0] sine_quarter(input int k, input int n);
    logic [63:0] step;
    logic [63:0] s;
    logic [63:0] v;
    logic [63:0] top;
    step = PI_Q62 >> ($clog2(n) - 1);
    s    = sine_q62(step * 64'(k));
    v    = (s + (64'd1 << (61 - (SAMPLE_BITS - 1)))) >> (62 - (SAMPLE_BITS - 1));
    top  = (64'd1 << (SAMPLE_BITS - 1)) - 64'd1;
    if (v > top) begin
      v = top;
    end
    return v[SAMPLE_BITS-1:0];
  endfunction

  // Full-wave table entry i, folded from the quarter wave.
  function automatic logic [SAMPLE_BITS-1:0] sine_entry(input int i, input int n);
    int q;
    q = n >> 2;
    if (i <= q) begin
      return sine_quarter(i, n);
    end else if (i <= 2 * q) begin
      return sine_quarter(2 * q - i, n);
    end else if (i < 3 * q) begin
      return -sine_quarter(i - 2 * q, n);
    end else begin
      return -sine_quarter(n - i, n);
    end
  endfunction

endpackage

`default_nettype wire

/* sv/nmx_front.sv */
// Front end: takes input transactions, decodes the command and forms the PLL gain deltas.
`default_nettype none

module nmx_front #(
  parameter int PHASE_BITS = nmx_pkg::PHASE_BITS_DEF
) (
  input  wire                                   clk_i,
  input  wire                                   rst_ni,
  input  wire                                   cfg_valid_i,
  input  wire [nmx_pkg::CFG_INDEX_BITS-1:0]     cfg_index_i,
  input  wire [nmx_pkg::GAIN_BITS-1:0]          cfg_data_i,
  input  wire                                   in_valid_i,
  output logic                                  in_ready_o,
  input  wire [nmx_pkg::CMD_BITS-1:0]           command_i,
  input  wire [nmx_pkg::SAMPLE_BITS-1:0]        sample_i_i,
  input  wire [nmx_pkg::SAMPLE_BITS-1:0]        sample_q_i,
  input  wire [nmx_pkg::WORD_BITS-1:0]          angle_word_i,
  input  wire [nmx_pkg::WORD_BITS-1:0]          phase_error_i,
  output logic                                  out_valid_o,
  input  wire                                   out_ready_i,
  output nmx_pkg::op_ctrl_t                     ctrl_o,
  output logic [nmx_pkg::SAMPLE_BITS-1:0]       xi_o,
  output logic [nmx_pkg::SAMPLE_BITS-1:0]       xq_o,
  output logic [PHASE_BITS-1:0]                 freq_opd_o,
  output logic [PHASE_BITS-1:0]                 phase_opd_o
);

  localparam int SW = nmx_pkg::SAMPLE_BITS;
  localparam int WB = nmx_pkg::WORD_BITS;
  localparam int GB = nmx_pkg::GAIN_BITS;
  // Product width of a signed word times an unsigned gain.
  localparam int PW = WB + GB + 1;
  // Bits of the product that survive rounding by 2^16 and wrapping to a word.
  localparam int KW = WB + 16;

  logic [GB-1:0] freq_gain_q;
  logic [GB-1:0] phase_gain_q;

  logic                  valid_q;
  nmx_pkg::op_ctrl_t     ctrl_q, ctrl_d;
  logic                  pll_q, pll_d;
  logic [SW-1:0]         xi_q;
  logic [SW-1:0]         xq_q;
  logic [PHASE_BITS-1:0] word_q;
  logic [KW-1:0]         prod_f_q;
  logic [KW-1:0]         prod_p_q;

  logic signed [PW-1:0]  prod_f;
  logic signed [PW-1:0]  prod_p;
  logic                  take;
  logic [WB-1:0]         delta_f;
  logic [WB-1:0]         delta_p;

  function automatic logic [PHASE_BITS-1:0] to_ph(input logic [WB-1:0] w);
    logic [PHASE_BITS+WB-1:0] t;
    t = {w, {PHASE_BITS{1'b0}}};
    return t[PHASE_BITS+WB-1:WB];
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      freq_gain_q  <= nmx_pkg::FREQ_GAIN_RESET;
      phase_gain_q <= nmx_pkg::PHASE_GAIN_RESET;
    end else if (cfg_valid_i) begin
      if (cfg_index_i == nmx_pkg::REG_FREQ_GAIN) begin
        freq_gain_q <= cfg_data_i;
      end else if (cfg_index_i == nmx_pkg::REG_PHASE_GAIN) begin
        phase_gain_q <= cfg_data_i;
      end
    end
  end

  always_comb begin
    ctrl_d = '{mix: nmx_pkg::MIX_NONE, fop: nmx_pkg::FREQ_KEEP, pop: nmx_pkg::PH_STEP};
    pll_d  = 1'b0;
    unique case (nmx_pkg::cmd_e'(command_i))
      nmx_pkg::CMD_MIX_UP:    ctrl_d.mix = nmx_pkg::MIX_UP;
      nmx_pkg::CMD_MIX_DOWN:  ctrl_d.mix = nmx_pkg::MIX_DOWN;
      nmx_pkg::CMD_PLL: begin
        ctrl_d.fop = nmx_pkg::FREQ_ADD;
        ctrl_d.pop = nmx_pkg::PH_ADD;
        pll_d      = 1'b1;
      end
      nmx_pkg::CMD_SET_FREQ: begin
        ctrl_d.fop = nmx_pkg::FREQ_LOAD;
        ctrl_d.pop = nmx_pkg::PH_KEEP;
      end
      nmx_pkg::CMD_ADJ_FREQ: begin
        ctrl_d.fop = nmx_pkg::FREQ_ADD;
        ctrl_d.pop = nmx_pkg::PH_KEEP;
      end
      nmx_pkg::CMD_SET_PHASE: ctrl_d.pop = nmx_pkg::PH_LOAD;
      nmx_pkg::CMD_ADJ_PHASE: ctrl_d.pop = nmx_pkg::PH_ADD;
      nmx_pkg::CMD_STEP:      ctrl_d.pop = nmx_pkg::PH_STEP;
      default:                ctrl_d.pop = nmx_pkg::PH_STEP;
    endcase
  end

  assign prod_f     = $signed(phase_error_i) * $signed({1'b0, freq_gain_q});
  assign prod_p     = $signed(phase_error_i) * $signed({1'b0, phase_gain_q});
  assign in_ready_o = !valid_q || out_ready_i;
  assign take       = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_ready_o) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      ctrl_q   <= ctrl_d;
      pll_q    <= pll_d;
      xi_q     <= sample_i_i;
      xq_q     <= sample_q_i;
      word_q   <= to_ph(angle_word_i);
      prod_f_q <= prod_f[KW-1:0];
      prod_p_q <= prod_p[KW-1:0];
    end
  end

  // Round to nearest at bit 16, ties upward, keep one word.
  assign delta_f = prod_f_q[KW-1:16] + {{(WB-1){1'b0}}, prod_f_q[15]};
  assign delta_p = prod_p_q[KW-1:16] + {{(WB-1){1'b0}}, prod_p_q[15]};

  assign out_valid_o = valid_q;
  assign ctrl_o      = ctrl_q;
  assign xi_o        = xi_q;
  assign xq_o        = xq_q;
  assign freq_opd_o  = pll_q ? to_ph(delta_f) : word_q;
  assign phase_opd_o = pll_q ? to_ph(delta_p) : word_q;

endmodule

`default_nettype wire

/* sv/nmx_queue.sv */
// Small register queue between the front end and the back end.
`default_nettype none

module nmx_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = nmx_pkg::QUEUE_DEPTH_DEF
) (
  input  wire              clk_i,
  input  wire              rst_ni,
  input  wire              in_valid_i,
  output logic             in_ready_o,
  input  wire [WIDTH-1:0]  in_data_i,
  output logic             out_valid_o,
  input  wire              out_ready_i,
  output logic [WIDTH-1:0] out_data_o
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [AW-1:0]    wr_ptr_q;
  logic [AW-1:0]    rd_ptr_q;
  logic [AW:0]      count_q;
  logic             push;
  logic             pop;

  assign in_ready_o  = count_q != (AW + 1)'(DEPTH);
  assign out_valid_o = count_q != '0;
  assign push        = in_valid_i && in_ready_o;
  assign pop         = out_valid_o && out_ready_i;
  assign out_data_o  = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= in_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push) begin
        wr_ptr_q <= (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop) begin
        rd_ptr_q <= (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (push && !pop) begin
        count_q <= count_q + 1'b1;
      end else if (pop && !push) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= (AW + 1)'(DEPTH))
    else $error("queue fill count exceeds its depth");

  a_count_up: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push && !pop) |=> count_q == $past(count_q) + 1'b1)
    else $error("queue fill count missed a push");

endmodule

`default_nettype wire

/* sv/nmx_back.sv */
// Back end: phase and frequency state, sine table reads, complex mixer and output register.
`default_nettype none

module nmx_back #(
  parameter int TABLE_ENTRIES = nmx_pkg::TABLE_ENTRIES_DEF,
  parameter int PHASE_BITS    = nmx_pkg::PHASE_BITS_DEF
) (
  input  wire                               clk_i,
  input  wire                               rst_ni,
  input  wire                               in_valid_i,
  output logic                              in_ready_o,
  input  wire nmx_pkg::op_ctrl_t            ctrl_i,
  input  wire [nmx_pkg::SAMPLE_BITS-1:0]    xi_i,
  input  wire [nmx_pkg::SAMPLE_BITS-1:0]    xq_i,
  input  wire [PHASE_BITS-1:0]              freq_opd_i,
  input  wire [PHASE_BITS-1:0]              phase_opd_i,
  output logic                              out_valid_o,
  input  wire                               out_ready_i,
  output logic [nmx_pkg::SAMPLE_BITS-1:0]   out_i_o,
  output logic [nmx_pkg::SAMPLE_BITS-1:0]   out_q_o,
  output logic [nmx_pkg::SAMPLE_BITS-1:0]   sine_o,
  output logic [nmx_pkg::SAMPLE_BITS-1:0]   cosine_o,
  output logic [nmx_pkg::WORD_BITS-1:0]     phase_now_o,
  output logic [nmx_pkg::WORD_BITS-1:0]     freq_now_o
);

  localparam int SW    = nmx_pkg::SAMPLE_BITS;
  localparam int WB    = nmx_pkg::WORD_BITS;
  localparam int PW    = 2 * SW;
  localparam int IB    = $clog2(TABLE_ENTRIES);
  localparam int SHIFT = PHASE_BITS - IB;
  localparam logic [PHASE_BITS-1:0] HALF    = PHASE_BITS'(1) << (SHIFT - 1);
  localparam logic [IB-1:0]         QUARTER = IB'(TABLE_ENTRIES / 4);
  localparam logic [SW-1:0] SIN_RESET = nmx_pkg::sine_entry(0, TABLE_ENTRIES);
  localparam logic [SW-1:0] COS_RESET = nmx_pkg::sine_entry(TABLE_ENTRIES / 4, TABLE_ENTRIES);
  localparam logic signed [SW+2:0] R_MAX = {4'b0000, {(SW - 1){1'b1}}};
  localparam logic signed [SW+2:0] R_MIN = {4'b1111, {(SW - 1){1'b0}}};

  logic [SW-1:0] rom [TABLE_ENTRIES];

  for (genvar g = 0; g < TABLE_ENTRIES; g++) begin : g_rom
    localparam logic [SW-1:0] Entry = nmx_pkg::sine_entry(g, TABLE_ENTRIES);
    assign rom[g] = Entry;
  end

  // Phase is kept twice: plain, and biased by half a table step for indexing.
  logic [PHASE_BITS-1:0] phase_q, phase_d;
  logic [PHASE_BITS-1:0] bias_q, bias_d;
  logic [PHASE_BITS-1:0] freq_q, freq_d;
  logic [SW-1:0]         sin_q;
  logic [SW-1:0]         cos_q;
  logic [IB-1:0]         idx_s;
  logic [IB-1:0]         idx_c;

  logic                  en;
  logic                  pop;

  logic                  v1_q;
  nmx_pkg::mix_e         mix1_q;
  logic signed [SW-1:0]  xi1_q, xq1_q, sin1_q, cos1_q;
  logic [WB-1:0]         ph1_q, fr1_q;

  logic                  v2_q;
  nmx_pkg::mix_e         mix2_q;
  logic signed [PW-1:0]  pa_q, pb_q, pc_q, pd_q;
  logic [SW-1:0]         sin2_q, cos2_q;
  logic [WB-1:0]         ph2_q, fr2_q;

  logic                  out_valid_q;
  logic [SW-1:0]         yi_q, yq_q, sin3_q, cos3_q;
  logic [WB-1:0]         ph3_q, fr3_q;

  logic signed [PW:0]    sum_i;
  logic signed [PW:0]    sum_q;
  logic [SW-1:0]         yi_d;
  logic [SW-1:0]         yq_d;

  function automatic logic [WB-1:0] from_ph(input logic [PHASE_BITS-1:0] p);
    logic [PHASE_BITS+WB-1:0] t;
    t = {p, {WB{1'b0}}};
    return t[PHASE_BITS+WB-1:PHASE_BITS];
  endfunction

  // Round to nearest at the fraction point, ties upward, then saturate.
  function automatic logic [SW-1:0] round_sat(input logic signed [PW:0] s);
    logic signed [PW+1:0] t;
    logic signed [SW+2:0] r;
    t = {s[PW], s} + (PW + 2)'(1 << (SW - 2));
    r = t[PW+1:SW-1];
    if (r > R_MAX) begin
      return R_MAX[SW-1:0];
    end else if (r < R_MIN) begin
      return R_MIN[SW-1:0];
    end else begin
      return r[SW-1:0];
    end
  endfunction

  // The whole back end advances together whenever the output register can move.
  assign en         = !out_valid_q || out_ready_i;
  assign pop        = en && in_valid_i;
  assign in_ready_o = en;

  always_comb begin
    freq_d  = freq_q;
    phase_d = phase_q;
    bias_d  = bias_q;
    if (pop) begin
      unique case (ctrl_i.fop)
        nmx_pkg::FREQ_LOAD: freq_d = freq_opd_i;
        nmx_pkg::FREQ_ADD:  freq_d = freq_q + freq_opd_i;
        default:            freq_d = freq_q;
      endcase
      unique case (ctrl_i.pop)
        nmx_pkg::PH_LOAD: begin
          phase_d = phase_opd_i;
          bias_d  = phase_opd_i + HALF;
        end
        nmx_pkg::PH_ADD: begin
          phase_d = phase_q + phase_opd_i;
          bias_d  = bias_q + phase_opd_i;
        end
        nmx_pkg::PH_STEP: begin
          phase_d = phase_q + freq_q;
          bias_d  = bias_q + freq_q;
        end
        default: begin
          phase_d = phase_q;
          bias_d  = bias_q;
        end
      endcase
    end
  end

  assign idx_s = bias_d[PHASE_BITS-1 -: IB];
  assign idx_c = idx_s + QUARTER;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= '0;
      bias_q  <= HALF;
      freq_q  <= '0;
      sin_q   <= SIN_RESET;
      cos_q   <= COS_RESET;
    end else begin
      phase_q <= phase_d;
      bias_q  <= bias_d;
      freq_q  <= freq_d;
      // Table reads follow the next phase so they match the state at the next pop.
      sin_q   <= rom[idx_s];
      cos_q   <= rom[idx_c];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q        <= 1'b0;
      v2_q        <= 1'b0;
      out_valid_q <= 1'b0;
    end else if (en) begin
      v1_q        <= pop;
      v2_q        <= v1_q;
      out_valid_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop) begin
      mix1_q <= ctrl_i.mix;
      xi1_q  <= xi_i;
      xq1_q  <= xq_i;
      sin1_q <= sin_q;
      cos1_q <= cos_q;
      ph1_q  <= from_ph(phase_d);
      fr1_q  <= from_ph(freq_d);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      mix2_q <= mix1_q;
      pa_q   <= xi1_q * cos1_q;
      pb_q   <= xq1_q * sin1_q;
      pc_q   <= xi1_q * sin1_q;
      pd_q   <= xq1_q * cos1_q;
      sin2_q <= sin1_q;
      cos2_q <= cos1_q;
      ph2_q  <= ph1_q;
      fr2_q  <= fr1_q;
    end
  end

  always_comb begin
    sum_i = '0;
    sum_q = '0;
    yi_d  = '0;
    yq_d  = '0;
    unique case (mix2_q)
      nmx_pkg::MIX_UP: begin
        sum_i = {pa_q[PW-1], pa_q} - {pb_q[PW-1], pb_q};
        sum_q = {pc_q[PW-1], pc_q} + {pd_q[PW-1], pd_q};
        yi_d  = round_sat(sum_i);
        yq_d  = round_sat(sum_q);
      end
      nmx_pkg::MIX_DOWN: begin
        sum_i = {pa_q[PW-1], pa_q} + {pb_q[PW-1], pb_q};
        sum_q = {pd_q[PW-1], pd_q} - {pc_q[PW-1], pc_q};
        yi_d  = round_sat(sum_i);
        yq_d  = round_sat(sum_q);
      end
      default: begin
        yi_d = '0;
        yq_d = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      yi_q   <= yi_d;
      yq_q   <= yq_d;
      sin3_q <= sin2_q;
      cos3_q <= cos2_q;
      ph3_q  <= ph2_q;
      fr3_q  <= fr2_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_i_o     = yi_q;
  assign out_q_o     = yq_q;
  assign sine_o      = sin3_q;
  assign cosine_o    = cos3_q;
  assign phase_now_o = ph3_q;
  assign freq_now_o  = fr3_q;

  a_state_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !pop |=> $stable(phase_q) && $stable(freq_q) && $stable(bias_q))
    else $error("oscillator state changed without a transaction");

  a_pipe_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !en |=> v1_q == $past(v1_q) && v2_q == $past(v2_q))
    else $error("back end stages moved while the output was stalled");

endmodule

`default_nettype wire

/* sv/nco_mixer_with_pll_core.sv */
// Top level of the NCO mixer with PLL: front end, queue and back end.
//
// Channel    Direction  Handshake                     Payload
// s_axis     in         s_axis_tvalid/s_axis_tready   tuser command, tdata samples, words
// m_axis     out        m_axis_tvalid/m_axis_tready   tdata mixed sample, sine, cosine, state
// cfg        in         cfg_valid_i/cfg_ready_o       cfg_index_i, cfg_data_i
//
// One transaction is accepted per clock when the output is drained; the phase and
// frequency registers each close their loop through a single adder per command.
// An accepted input passes through the front register, the queue, then the state/table
// stage, the product stage and the round and saturate register before its result is valid.
// Reset clears phase and frequency to zero and loads the default gains.
// A stalled output freezes the back end; the queue and the front end keep taking
// transactions until the queue is full, so the two sides stall independently.
`default_nettype none

module nco_mixer_with_pll_core #(
  parameter int TABLE_ENTRIES = nmx_pkg::TABLE_ENTRIES_DEF,
  parameter int PHASE_BITS    = nmx_pkg::PHASE_BITS_DEF,
  parameter int QUEUE_DEPTH   = nmx_pkg::QUEUE_DEPTH_DEF
) (
  input  wire                                clk_i,
  input  wire                                rst_ni,
  input  wire                                s_axis_tvalid,
  output logic                               s_axis_tready,
  // sample_i [15:0], sample_q [31:16], angle_word [63:32], phase_error [95:64]
  input  wire [95:0]                         s_axis_tdata,
  // command [2:0]
  input  wire [nmx_pkg::CMD_BITS-1:0]        s_axis_tuser,
  output logic                               m_axis_tvalid,
  input  wire                                m_axis_tready,
  // out_i [15:0], out_q [31:16], sine_value [47:32], cosine_value [63:48],
  // phase_now [95:64], freq_now [127:96]
  output logic [127:0]                       m_axis_tdata,
  input  wire                                cfg_valid_i,
  output logic                               cfg_ready_o,
  input  wire [nmx_pkg::CFG_INDEX_BITS-1:0]  cfg_index_i,
  input  wire [nmx_pkg::GAIN_BITS-1:0]       cfg_data_i
);

  localparam int SW = nmx_pkg::SAMPLE_BITS;
  localparam int WB = nmx_pkg::WORD_BITS;
  localparam int CW = $bits(nmx_pkg::op_ctrl_t);
  localparam int QW = CW + 2 * SW + 2 * PHASE_BITS;

  logic                  f_valid;
  logic                  f_ready;
  nmx_pkg::op_ctrl_t     f_ctrl;
  logic [SW-1:0]         f_xi;
  logic [SW-1:0]         f_xq;
  logic [PHASE_BITS-1:0] f_fopd;
  logic [PHASE_BITS-1:0] f_popd;

  logic                  b_valid;
  logic                  b_ready;
  logic [QW-1:0]         b_data;
  nmx_pkg::op_ctrl_t     b_ctrl;

  logic [SW-1:0]         out_i, out_q, sine_v, cosine_v;
  logic [WB-1:0]         phase_now, freq_now;

  assign cfg_ready_o = 1'b1;

  nmx_front #(
    .PHASE_BITS (PHASE_BITS)
  ) u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .in_valid_i    (s_axis_tvalid),
    .in_ready_o    (s_axis_tready),
    .command_i     (s_axis_tuser),
    .sample_i_i    (s_axis_tdata[15:0]),
    .sample_q_i    (s_axis_tdata[31:16]),
    .angle_word_i  (s_axis_tdata[63:32]),
    .phase_error_i (s_axis_tdata[95:64]),
    .out_valid_o   (f_valid),
    .out_ready_i   (f_ready),
    .ctrl_o        (f_ctrl),
    .xi_o          (f_xi),
    .xq_o          (f_xq),
    .freq_opd_o    (f_fopd),
    .phase_opd_o   (f_popd)
  );

  nmx_queue #(
    .WIDTH (QW),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (f_valid),
    .in_ready_o  (f_ready),
    .in_data_i   ({f_ctrl, f_xi, f_xq, f_fopd, f_popd}),
    .out_valid_o (b_valid),
    .out_ready_i (b_ready),
    .out_data_o  (b_data)
  );

  assign b_ctrl = nmx_pkg::op_ctrl_t'(b_data[QW-1 -: CW]);

  nmx_back #(
    .TABLE_ENTRIES (TABLE_ENTRIES),
    .PHASE_BITS    (PHASE_BITS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (b_valid),
    .in_ready_o  (b_ready),
    .ctrl_i      (b_ctrl),
    .xi_i        (b_data[2*PHASE_BITS+2*SW-1 -: SW]),
    .xq_i        (b_data[2*PHASE_BITS+SW-1 -: SW]),
    .freq_opd_i  (b_data[2*PHASE_BITS-1 -: PHASE_BITS]),
    .phase_opd_i (b_data[PHASE_BITS-1:0]),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_i_o     (out_i),
    .out_q_o     (out_q),
    .sine_o      (sine_v),
    .cosine_o    (cosine_v),
    .phase_now_o (phase_now),
    .freq_now_o  (freq_now)
  );

  assign m_axis_tdata = {freq_now, phase_now, cosine_v, sine_v, out_q, out_i};

endmodule

`default_nettype wire

/* tb/tb_nco_mixer_with_pll_core.sv */
// Self-checking testbench for the NCO mixer with PLL: driver, monitor and a cycle-free predictor.
`timescale 1ns / 1ps

module tb_nco_mixer_with_pll_core;

  localparam int          GW        = nmx_pkg::GAIN_BITS;
  localparam int          IW        = nmx_pkg::CFG_INDEX_BITS;
  localparam int          TAB_SIZE  = 1024;
  localparam int          QUARTER   = TAB_SIZE / 4;
  localparam logic [31:0] HALF_STEP = 32'h0020_0000;
  localparam real         PI_REAL   = 3.14159265358979323846;
  localparam logic [GW-1:0] GAIN_MAX     = '1;
  localparam logic [IW-1:0] REG_SPARE_LO = nmx_pkg::REG_PHASE_GAIN + 1'b1;
  localparam logic [IW-1:0] REG_SPARE_HI = '1;

  typedef struct {
    nmx_pkg::cmd_e      cmd;
    logic signed [15:0] si;
    logic signed [15:0] sq;
    logic [31:0]        word;
    logic signed [31:0] err;
  } nco_item_t;

  // Packed from the top field down so that it overlays m_axis_tdata directly.
  typedef struct packed {
    logic [31:0] fr;
    logic [31:0] ph;
    logic [15:0] cosine;
    logic [15:0] sine;
    logic [15:0] oq;
    logic [15:0] oi;
  } nco_out_t;

  typedef struct {
    logic [IW-1:0] addr;
    logic [GW-1:0] data;
  } reg_write_t;

  logic                         clk_i         = 1'b0;
  logic                         rst_ni        = 1'b0;
  logic                         s_axis_tvalid = 1'b0;
  logic                         s_axis_tready;
  logic [95:0]                  s_axis_tdata  = '0;
  logic [nmx_pkg::CMD_BITS-1:0] s_axis_tuser  = nmx_pkg::CMD_STEP;
  logic                         m_axis_tvalid;
  logic                         m_axis_tready = 1'b0;
  logic [127:0]                 m_axis_tdata;
  logic                         cfg_valid_i   = 1'b0;
  logic                         cfg_ready_o;
  logic [IW-1:0]                cfg_index_i   = '0;
  logic [GW-1:0]                cfg_data_i    = '0;

  // Predictor state: oscillator registers, gains and the sine table.
  logic [31:0]          phase_acc;
  logic [31:0]          freq_word;
  logic [GW-1:0]        freq_gain_m;
  logic [GW-1:0]        phase_gain_m;
  logic signed [15:0]   sine_tab [0:TAB_SIZE-1];
  int                   quarter_tab [0:QUARTER];

  nco_item_t  stim_q [$];
  nco_out_t   expected_out_q [$];
  reg_write_t reg_writes [$];
  nco_item_t  drive_item;
  int         queued_cnt    = 0;
  int         accepted_cnt  = 0;
  int         mismatch_cnt  = 0;
  int         send_idle_pct = 0;
  int         recv_idle_pct = 0;

  nco_mixer_with_pll_core dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // Round to nearest at bit 15 with ties upward, then clamp to Q1.15.
  function automatic logic [15:0] round_sat(input longint acc);
    longint r;
    r = (acc + 64'sd16384) >>> 15;
    if (r > 32767) r = 32767;
    if (r < -32768) r = -32768;
    return r[15:0];
  endfunction

  // round(err * gain / 2^16) modulo one turn.
  function automatic logic [31:0] gain_step(input logic signed [31:0] err,
                                            input logic [GW-1:0] gain);
    longint p;
    p = longint'(err) * longint'(gain);
    p = (p + 64'sd32768) >>> 16;
    return p[31:0];
  endfunction

  // Result of one command; updates the oscillator registers as the block does.
  function automatic nco_out_t step_nco(input nco_item_t it);
    logic [31:0] rounded;
    logic [9:0]  sidx;
    logic [9:0]  cidx;
    longint      s;
    longint      c;
    longint      xi;
    longint      xq;
    nco_out_t    r;
    rounded = phase_acc + HALF_STEP;
    sidx    = rounded[31:22];
    cidx    = sidx + 10'(QUARTER);
    s       = longint'(sine_tab[sidx]);
    c       = longint'(sine_tab[cidx]);
    xi      = longint'(it.si);
    xq      = longint'(it.sq);
    r       = '0;
    r.sine   = sine_tab[sidx];
    r.cosine = sine_tab[cidx];
    case (it.cmd)
      nmx_pkg::CMD_MIX_UP: begin
        r.oi      = round_sat(xi * c - xq * s);
        r.oq      = round_sat(xi * s + xq * c);
        phase_acc = phase_acc + freq_word;
      end
      nmx_pkg::CMD_MIX_DOWN: begin
        r.oi      = round_sat(xi * c + xq * s);
        r.oq      = round_sat(xq * c - xi * s);
        phase_acc = phase_acc + freq_word;
      end
      nmx_pkg::CMD_PLL: begin
        freq_word = freq_word + gain_step(it.err, freq_gain_m);
        phase_acc = phase_acc + gain_step(it.err, phase_gain_m);
      end
      nmx_pkg::CMD_SET_FREQ:  freq_word = it.word;
      nmx_pkg::CMD_ADJ_FREQ:  freq_word = freq_word + it.word;
      nmx_pkg::CMD_SET_PHASE: phase_acc = it.word;
      nmx_pkg::CMD_ADJ_PHASE: phase_acc = phase_acc + it.word;
      default:                phase_acc = phase_acc + freq_word;
    endcase
    r.ph = phase_acc;
    r.fr = freq_word;
    return r;
  endfunction

  task automatic push_cmd(input nmx_pkg::cmd_e cmd, input logic [15:0] si,
                          input logic [15:0] sq, input logic [31:0] word,
                          input logic [31:0] err);
    nco_item_t it;
    it.cmd  = cmd;
    it.si   = si;
    it.sq   = sq;
    it.word = word;
    it.err  = err;
    stim_q.push_back(it);
    queued_cnt++;
  endtask

  task automatic push_random(input int n);
    int            r;
    nmx_pkg::cmd_e cmd;
    logic [15:0]   si;
    logic [15:0]   sq;
    logic [31:0]   word;
    logic [31:0]   err;
    repeat (n) begin
      r = $urandom_range(99);
      if (r < 25)      cmd = nmx_pkg::CMD_MIX_UP;
      else if (r < 50) cmd = nmx_pkg::CMD_MIX_DOWN;
      else if (r < 62) cmd = nmx_pkg::CMD_PLL;
      else if (r < 68) cmd = nmx_pkg::CMD_SET_FREQ;
      else if (r < 74) cmd = nmx_pkg::CMD_ADJ_FREQ;
      else if (r < 80) cmd = nmx_pkg::CMD_SET_PHASE;
      else if (r < 86) cmd = nmx_pkg::CMD_ADJ_PHASE;
      else             cmd = nmx_pkg::CMD_STEP;
      si = ($urandom_range(9) == 0) ? ($urandom_range(1) ? 16'h8000 : 16'h7fff)
                                    : 16'($urandom);
      sq = ($urandom_range(9) == 0) ? ($urandom_range(1) ? 16'h8000 : 16'h7fff)
                                    : 16'($urandom);
      word = ($urandom_range(3) == 0) ? ($urandom >> $urandom_range(31)) : $urandom;
      if ($urandom_range(9) == 0) begin
        err = $urandom_range(1) ? 32'h8000_0000 : 32'h7fff_ffff;
      end else begin
        err = 32'($signed($urandom) >>> $urandom_range(31));
      end
      push_cmd(cmd, si, sq, word, err);
    end
  endtask

  // Returns once every queued item is accepted and every result is back.
  task automatic wait_drained();
    do @(posedge clk_i);
    while (accepted_cnt != queued_cnt || expected_out_q.size() != 0);
  endtask

  // Runs the pending register writes back to back; called only when idle.
  task automatic apply_reg_writes();
    reg_write_t w;
    while (reg_writes.size() != 0) begin
      w = reg_writes.pop_front();
      cfg_valid_i <= 1'b1;
      cfg_index_i <= w.addr;
      cfg_data_i  <= w.data;
      do @(posedge clk_i);
      while (!cfg_ready_o);
      if (w.addr == nmx_pkg::REG_FREQ_GAIN) begin
        freq_gain_m = w.data;
      end else if (w.addr == nmx_pkg::REG_PHASE_GAIN) begin
        phase_gain_m = w.data;
      end
    end
    cfg_valid_i <= 1'b0;
  endtask

  task automatic queue_write(input logic [IW-1:0] addr, input logic [GW-1:0] data);
    reg_write_t w;
    w.addr = addr;
    w.data = data;
    reg_writes.push_back(w);
  endtask

  task automatic check_result(input logic [127:0] d);
    nco_out_t got;
    nco_out_t want;
    logic     bad;
    got = nco_out_t'(d);
    if (expected_out_q.size() == 0) begin
      if (mismatch_cnt < 10) $display("%0t: result with none expected: %h", $time, d);
      mismatch_cnt++;
    end else begin
      want = expected_out_q.pop_front();
      bad = (got.oi !== want.oi) || (got.oq !== want.oq) || (got.sine !== want.sine) ||
            (got.cosine !== want.cosine) || (got.ph !== want.ph) || (got.fr !== want.fr);
      if (bad) begin
        if (mismatch_cnt < 10) begin
          $display("%0t: expected i=%h q=%h sin=%h cos=%h phase=%h freq=%h", $time,
                   want.oi, want.oq, want.sine, want.cosine, want.ph, want.fr);
          $display("%0t:   actual i=%h q=%h sin=%h cos=%h phase=%h freq=%h", $time,
                   got.oi, got.oq, got.sine, got.cosine, got.ph, got.fr);
        end
        mismatch_cnt++;
      end
    end
  endtask

  // Driver: each accepted transaction is predicted the moment it is taken.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata  <= '0;
      s_axis_tuser  <= nmx_pkg::CMD_STEP;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        expected_out_q.push_back(step_nco(drive_item));
        accepted_cnt++;
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (stim_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          drive_item = stim_q.pop_front();
          s_axis_tvalid <= 1'b1;
          s_axis_tdata  <= {drive_item.err, drive_item.word, drive_item.sq, drive_item.si};
          s_axis_tuser  <= drive_item.cmd;
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // Monitor with random back-pressure.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) check_result(m_axis_tdata);
      m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  initial begin
    #400000;
    $display("TEST FAILED");
    $finish;
  end

  initial begin
    real qv;
    // Quarter wave rounded with ties upward, then folded into the full table.
    for (int k = 0; k <= QUARTER; k++) begin
      qv = $floor(32768.0 * $sin(PI_REAL * k / (2.0 * QUARTER)) + 0.5);
      if (qv > 32767.0) qv = 32767.0;
      quarter_tab[k] = $rtoi(qv);
    end
    for (int i = 0; i < TAB_SIZE; i++) begin
      if (i <= QUARTER)            sine_tab[i] = 16'(quarter_tab[i]);
      else if (i <= 2 * QUARTER)   sine_tab[i] = 16'(quarter_tab[2 * QUARTER - i]);
      else if (i < 3 * QUARTER)    sine_tab[i] = 16'(-quarter_tab[i - 2 * QUARTER]);
      else                         sine_tab[i] = 16'(-quarter_tab[TAB_SIZE - i]);
    end
    phase_acc    = '0;
    freq_word    = '0;
    freq_gain_m  = nmx_pkg::FREQ_GAIN_RESET;
    phase_gain_m = nmx_pkg::PHASE_GAIN_RESET;

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    send_idle_pct = 12;
    recv_idle_pct = 83;
    // Directed: extreme samples at zero, eighth and quarter turn, table index wrap,
    // frequency and phase wrap, PLL with extreme errors, don't-care fields set.
    push_cmd(nmx_pkg::CMD_STEP,      16'h0000, 16'h0000, 32'h0000_0000, 32'h0000_0000);
    push_cmd(nmx_pkg::CMD_MIX_UP,    16'h8000, 16'h8000, 32'h0000_0000, 32'h0000_0000);
    push_cmd(nmx_pkg::CMD_MIX_DOWN,  16'h7fff, 16'h8000, 32'h0000_0000, 32'h0000_0000);
    push_cmd(nmx_pkg::CMD_SET_PHASE, 16'h0000, 16'h0000, 32'h2000_0000, 32'h0000_0000);
    push_cmd(nmx_pkg::CMD_MIX_UP,    16'h8000, 16'h7fff, 32'h0000_0000, 32'h0000_0000);
    push_cmd(nmx_pkg::CMD_MIX_DOWN,  16'h7fff, 16'h7fff, 32'h0000_0000, 32'h0000_0000);
    push_cmd(nmx_pkg::CMD_SET_PHASE, 16'h0000, 16'h0000, 32'h4000_0000, 32'h0000_0000);
    push_cmd(nmx_pkg::CMD_MIX_UP,    16'h7fff, 16'h7fff, 32'h0000_0000, 32'h0000_0000);
    push_cmd(nmx_pkg::CMD_SET_PHASE, 16'h0000, 16'h0000, 32'hffdf_ffff, 32'h0000_0000);
    push_cmd(nmx_pkg::CMD_STEP,      16'h0000, 16'h0000, 32'h0000_0000, 32'h0000_0000);
    push_cmd(nmx_pkg::CMD_SET_PHASE, 16'h0000, 16'h0000, 32'hffe0_0000, 32'h0000_0000);
    push_cmd(nmx_pkg::CMD_MIX_DOWN,  16'hffff, 16'h0001, 32'h0000_0000, 32'h0000_0000);
    push_cmd(nmx_pkg::CMD_SET_FREQ,  16'h0000, 16'h0000, 32'hffff_ffff, 32'h0000_0000);
    push_cmd(nmx_pkg::CMD_STEP,      16'h0000, 16'h0000, 32'h0000_0000, 32'h0000_0000);
    push_cmd(nmx_pkg::CMD_ADJ_FREQ,  16'h0000, 16'h0000, 32'h8000_0001, 32'h0000_0000);
    push_cmd(nmx_pkg::CMD_ADJ_PHASE, 16'h0000, 16'h0000, 32'hffff_ffff, 32'h0000_0000);
    push_cmd(nmx_pkg::CMD_PLL,       16'h0000, 16'h0000, 32'h0000_0000, 32'h7fff_ffff);
    push_cmd(nmx_pkg::CMD_PLL,       16'h0000, 16'h0000, 32'h0000_0000, 32'h8000_0000);
    push_cmd(nmx_pkg::CMD_PLL,       16'h0000, 16'h0000, 32'h0000_0000, 32'h0000_0000);
    push_cmd(nmx_pkg::CMD_PLL,       16'h0000, 16'h0000, 32'h0000_0000, 32'hffff_ffff);
    push_cmd(nmx_pkg::CMD_SET_FREQ,  16'h0000, 16'h0000, 32'h0000_0000, 32'h0000_0000);
    push_cmd(nmx_pkg::CMD_ADJ_PHASE, 16'h0000, 16'h0000, 32'h0000_0000, 32'h0000_0000);
    push_cmd(nmx_pkg::CMD_MIX_UP,    16'h0000, 16'h0000, 32'hffff_ffff, 32'hffff_ffff);
    wait_drained();
    push_random(100);
    // The sender holds here until the block has handed back everything.
    wait_drained();
    push_random(100);
    wait_drained();

    queue_write(nmx_pkg::REG_FREQ_GAIN, GAIN_MAX);
    queue_write(nmx_pkg::REG_PHASE_GAIN, '0);
    queue_write(REG_SPARE_LO, GW'($urandom));
    queue_write(REG_SPARE_HI, GW'($urandom));
    apply_reg_writes();
    send_idle_pct = 83;
    recv_idle_pct = 12;
    push_random(200);
    wait_drained();

    queue_write(nmx_pkg::REG_FREQ_GAIN, '0);
    queue_write(nmx_pkg::REG_PHASE_GAIN, GAIN_MAX);
    apply_reg_writes();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    push_random(200);
    wait_drained();

    queue_write(nmx_pkg::REG_PHASE_GAIN, GW'($urandom));
    queue_write(nmx_pkg::REG_FREQ_GAIN, GW'($urandom));
    apply_reg_writes();
    push_random(200);
    wait_drained();

    repeat (20) @(posedge clk_i);
    if (mismatch_cnt == 0 && expected_out_q.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
